/* src/gtb_pkg.sv */
// Shared types and constants for the graph traversal core.
package gtb_pkg;

    localparam int NODE_W     = 4;   // node index width
    localparam int ROW_W      = 16;  // adjacency row width
    localparam int CNT_W      = 5;   // node_count register width
    localparam int REG_IDX_W  = 1;   // configuration register index width
    localparam int CFG_W      = 5;   // configuration write data width
    localparam int S_TDATA_W  = 24;  // row_index + row_bits, padded to bytes
    localparam int M_TDATA_W  = 8;   // visited_node, padded to bytes

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } t_opcode;

    typedef enum logic {
        MODE_BFS = 1'b0,
        MODE_DFS = 1'b1
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NODE_COUNT  = 1'b0,
        REG_SEARCH_MODE = 1'b1
    } t_reg_idx;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

endpackage

/* src/gtb_stack.sv */
// Work stack storage for depth-first traversal: one write port, one registered read port.
module gtb_stack #(
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [gtb_pkg::NODE_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic [gtb_pkg::NODE_W-1:0]        o_rd_data
);

    logic [gtb_pkg::NODE_W-1:0] mem_stack [DEPTH];
    logic [gtb_pkg::NODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_stack[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem_stack[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/graph_traversal_bfs_dfs_core.sv */
// Graph traversal core: a load request (tuser low) writes one 16-bit adjacency row. A run
// request (tuser high) walks the graph from node 0, breadth-first through a queue or
// depth-first through a stack, and streams out every visited node in order with tlast on the
// final one. The core takes no new request until the run has loaded its last node into the
// output register. One neighbor-test unit scans the current row one node per cycle; in
// depth-first mode a stack entry whose node was already visited is skipped, and output
// backpressure can stall the core while it emits a node or finishes a run.
// Visit marks are flip-flops cleared at the start of each run, so there is no clearing pass.
module graph_traversal_bfs_dfs_core #(
    parameter int MAX_NODES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [gtb_pkg::S_TDATA_W-1:0]       i_s_tdata,   // [3:0] row_index, [19:4] row_bits
    input  logic                                i_s_tuser,   // [0] opcode
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gtb_pkg::M_TDATA_W-1:0]       o_m_tdata,   // [3:0] visited_node
    output logic                                o_m_tlast,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [gtb_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [gtb_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int CAP       = (MAX_NODES < gtb_pkg::ROW_W) ? MAX_NODES : gtb_pkg::ROW_W;
    localparam int IDX_W     = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int QC_W      = $clog2(CAP + 1);
    localparam int STK_DEPTH = CAP * CAP;
    localparam int SA_W      = $clog2(STK_DEPTH);
    localparam int SP_W      = $clog2(STK_DEPTH + 1);
    localparam int NW        = gtb_pkg::NODE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_POPW,
        ST_EMIT,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                     r_state;
    logic [gtb_pkg::CNT_W-1:0]  r_node_count;
    logic                       r_search_mode;
    logic [NW-1:0]              r_nlast;
    logic [CAP-1:0]             r_seen;
    logic [CAP-1:0]             r_done;
    logic [QC_W-1:0]            r_q_head;
    logic [QC_W-1:0]            r_q_tail;
    logic [SP_W-1:0]            r_sp;
    logic [NW-1:0]              r_j;
    logic [NW-1:0]              r_node;
    logic [NW-1:0]              r_pend;
    logic                       r_have_pend;
    logic                       r_m_valid;
    logic [NW-1:0]              r_m_node;
    logic                       r_m_last;
    logic [gtb_pkg::ROW_W-1:0]  r_row;
    logic [NW-1:0]              r_q_rd;

    logic [gtb_pkg::ROW_W-1:0]  mem_adj [gtb_pkg::ROW_W];
    logic [NW-1:0]              mem_q   [CAP];

    logic                       s_accept;
    logic                       run_start;
    logic                       load_wr;
    logic                       is_dfs;
    logic                       can_out;
    logic                       m_load;
    logic [NW-1:0]              nlast_eff;
    logic [NW-1:0]              n_node;
    logic [IDX_W-1:0]           mark_idx;
    logic                       n_take;
    logic                       scan_end;
    logic                       q_empty;
    logic                       q_re;
    logic                       q_we;
    logic [IDX_W-1:0]           q_wa;
    logic                       stk_we;
    logic                       stk_re;
    logic [SA_W-1:0]            stk_wa;
    logic [SP_W-1:0]            sp_dec;
    logic [NW-1:0]              stk_rd;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign run_start  = s_accept && (i_s_tuser == gtb_pkg::OP_RUN);
    assign load_wr    = s_accept && (i_s_tuser == gtb_pkg::OP_LOAD);
    assign is_dfs     = (r_search_mode == gtb_pkg::MODE_DFS);
    assign can_out    = !r_m_valid || i_m_tready;
    assign q_empty    = (r_q_head == r_q_tail);
    assign sp_dec     = r_sp - SP_W'(1);

    // Load the output register this cycle.
    assign m_load = can_out && (((r_state == ST_EMIT) && r_have_pend) || (r_state == ST_FINISH));

    // Clamp node_count to 1..CAP and keep the highest node index.
    always_comb begin
        if (r_node_count == '0) begin
            nlast_eff = '0;
        end else if (r_node_count > gtb_pkg::CNT_W'(CAP)) begin
            nlast_eff = NW'(CAP - 1);
        end else begin
            nlast_eff = NW'(r_node_count - gtb_pkg::CNT_W'(1));
        end
    end

    assign n_node   = is_dfs ? stk_rd : r_q_rd;
    assign mark_idx = (r_state == ST_SCAN) ? r_j[IDX_W-1:0] : n_node[IDX_W-1:0];

    // Neighbor test: edge present and target still eligible for this mode.
    assign n_take   = r_row[r_j] && (is_dfs ? !r_done[mark_idx] : !r_seen[mark_idx]);
    assign scan_end = is_dfs ? (r_j == '0) : (r_j == r_nlast);

    assign q_re  = (r_state == ST_POP) && !is_dfs && !q_empty;
    assign q_we  = (run_start && !is_dfs) || ((r_state == ST_SCAN) && !is_dfs && n_take);
    assign q_wa  = run_start ? '0 : r_q_tail[IDX_W-1:0];

    assign stk_re = (r_state == ST_POP) && is_dfs && (r_sp != '0);
    assign stk_we = (run_start && is_dfs) || ((r_state == ST_SCAN) && is_dfs && n_take);
    assign stk_wa = run_start ? '0 : r_sp[SA_W-1:0];

    gtb_stack #(
        .DEPTH (STK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (stk_wa),
        .i_wr_data (run_start ? NW'(0) : r_j),
        .i_rd_en   (stk_re),
        .i_rd_addr (sp_dec[SA_W-1:0]),
        .o_rd_data (stk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem_adj[i_s_tdata[NW-1:0]] <= i_s_tdata[NW +: gtb_pkg::ROW_W];
        end
        if (r_state == ST_POPW) begin
            r_row <= mem_adj[n_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            mem_q[q_wa] <= run_start ? NW'(0) : r_j;
        end
        if (q_re) begin
            r_q_rd <= mem_q[r_q_head[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_node_count  <= gtb_pkg::NODE_COUNT_RST;
            r_search_mode <= gtb_pkg::MODE_BFS;
            r_nlast       <= '0;
            r_seen        <= '0;
            r_done        <= '0;
            r_q_head      <= '0;
            r_q_tail      <= '0;
            r_sp          <= '0;
            r_j           <= '0;
            r_have_pend   <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gtb_pkg::REG_NODE_COUNT:  r_node_count  <= i_cfg_wdata;
                    gtb_pkg::REG_SEARCH_MODE: r_search_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (r_m_valid && i_m_tready && !m_load) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (run_start) begin
                        r_nlast     <= nlast_eff;
                        r_seen      <= '0;
                        r_done      <= '0;
                        r_q_head    <= '0;
                        r_q_tail    <= QC_W'(1);
                        r_sp        <= SP_W'(1);
                        r_have_pend <= 1'b0;
                        r_state     <= ST_POP;
                    end
                end
                ST_POP: begin
                    if (is_dfs) begin
                        if (r_sp == '0) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_sp    <= sp_dec;
                            r_state <= ST_POPW;
                        end
                    end else begin
                        if (q_empty) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_q_head <= r_q_head + QC_W'(1);
                            r_state  <= ST_POPW;
                        end
                    end
                end
                ST_POPW: begin
                    // drop a stack entry whose node was already visited
                    if (is_dfs && r_done[mark_idx]) begin
                        r_state <= ST_POP;
                    end else begin
                        r_node             <= n_node;
                        r_done[mark_idx]   <= 1'b1;
                        r_seen[mark_idx]   <= 1'b1;
                        r_state            <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold each node until the next one is known, so tlast lands right
                    if (!r_have_pend || can_out) begin
                        if (r_have_pend) begin
                            r_m_valid <= 1'b1;
                            r_m_node  <= r_pend;
                            r_m_last  <= 1'b0;
                        end
                        r_pend      <= r_node;
                        r_have_pend <= 1'b1;
                        r_j         <= is_dfs ? r_nlast : '0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (n_take) begin
                        r_seen[mark_idx] <= 1'b1;
                        if (is_dfs) begin
                            r_sp <= r_sp + SP_W'(1);
                        end else begin
                            r_q_tail <= r_q_tail + QC_W'(1);
                        end
                    end
                    if (scan_end) begin
                        r_state <= ST_POP;
                    end else begin
                        r_j <= is_dfs ? (r_j - NW'(1)) : (r_j + NW'(1));
                    end
                end
                ST_FINISH: begin
                    if (can_out) begin
                        r_m_valid   <= 1'b1;
                        r_m_node    <= r_pend;
                        r_m_last    <= 1'b1;
                        r_have_pend <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(gtb_pkg::M_TDATA_W - NW){1'b0}}, r_m_node};
    assign o_m_tlast  = r_m_last;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_have_pend)
        else $error("pending node left over after run");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_head <= r_q_tail) && (r_q_tail <= QC_W'(CAP)))
        else $error("queue pointers out of order");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STK_DEPTH))
        else $error("stack pointer beyond depth");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_j <= r_nlast) && (r_node <= r_nlast)))
        else $error("scan index beyond node count");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && can_out) |=> (r_state == ST_IDLE && o_m_tvalid && o_m_tlast))
        else $error("final node not flagged");

endmodule

/* bench/tb_top.sv */
// Testbench for the graph traversal core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROW_W         = gtb_pkg::ROW_W;
    localparam int NODE_W        = gtb_pkg::NODE_W;
    localparam int CNT_W         = gtb_pkg::CNT_W;
    localparam int CFG_W         = gtb_pkg::CFG_W;
    localparam int S_TDATA_W     = gtb_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = gtb_pkg::M_TDATA_W;
    localparam int REG_IDX_W     = gtb_pkg::REG_IDX_W;
    localparam int MAX_NODES     = 16;
    localparam int NODE_CAP      = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int STACK_DEPTH   = MAX_NODES * MAX_NODES;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 20;

    typedef enum logic [1:0] {
        MARK_UNSEEN  = 2'd0,
        MARK_PENDING = 2'd1,
        MARK_DONE    = 2'd2
    } t_mark;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } t_visit;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_we;
    logic [REG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_wdata;

    // predictor state
    logic [ROW_W-1:0]      adj_rows [ROW_W];
    logic [CNT_W-1:0]      cfg_node_count;
    gtb_pkg::t_mode        cfg_mode;
    t_visit                expected_visits [$];
    t_visit                oldest_visit;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    int error_count;
    int loads_sent;
    int runs_sent;
    int visits_checked;
    int configs_written;

    graph_traversal_bfs_dfs_core #(
        .MAX_NODES (MAX_NODES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Walk the graph as the core does and queue every visited node.
    task automatic predict_walk();
        int     n;
        int     node;
        int     q_head;
        int     q_tail;
        int     s_top;
        int     count;
        int     order  [MAX_NODES];
        int     work_q [MAX_NODES];
        int     work_s [STACK_DEPTH];
        t_mark  mark   [MAX_NODES];
        t_visit v;
        n = int'(cfg_node_count);
        if (n == 0) n = 1;
        if (n > NODE_CAP) n = NODE_CAP;
        foreach (mark[i]) mark[i] = MARK_UNSEEN;
        count = 0;
        if (cfg_mode == gtb_pkg::MODE_BFS) begin
            work_q[0] = 0;
            q_head = 0;
            q_tail = 1;
            while (q_head < q_tail && q_head < MAX_NODES) begin
                node = work_q[q_head];
                q_head++;
                mark[node] = MARK_DONE;
                for (int j = 0; j < n; j++) begin
                    if (adj_rows[node][j] && mark[j] == MARK_UNSEEN && q_tail < MAX_NODES) begin
                        work_q[q_tail] = j;
                        q_tail++;
                        mark[j] = MARK_PENDING;
                    end
                end
                order[count] = node;
                count++;
            end
        end else begin
            work_s[0] = 0;
            s_top = 1;
            while (s_top > 0) begin
                s_top--;
                node = work_s[s_top];
                if (mark[node] == MARK_DONE) continue;
                mark[node] = MARK_DONE;
                // push from the highest index down so the lowest neighbor pops first
                for (int k = n - 1; k >= 0; k--) begin
                    if (adj_rows[node][k] && mark[k] != MARK_DONE && s_top < STACK_DEPTH) begin
                        work_s[s_top] = k;
                        s_top++;
                        mark[k] = MARK_PENDING;
                    end
                end
                if (count < MAX_NODES) begin
                    order[count] = node;
                    count++;
                end
            end
        end
        for (int k = 0; k < count; k++) begin
            v.node = NODE_W'(order[k]);
            v.last = (k == count - 1);
            expected_visits.insert(expected_visits.size(), v);
        end
    endtask

    // Send one request; valid stays high on return so back-to-back requests need no drop.
    task automatic send_request(input gtb_pkg::t_opcode op, input logic [NODE_W-1:0] row_idx,
                                input logic [ROW_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(S_TDATA_W - ROW_W - NODE_W){1'b0}}, bits, row_idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (op == gtb_pkg::OP_LOAD) begin
            adj_rows[row_idx] = bits;
            loads_sent++;
        end else begin
            predict_walk();
            runs_sent++;
        end
    endtask

    task automatic send_run();
        send_request(gtb_pkg::OP_RUN, NODE_W'($urandom), ROW_W'($urandom));
    endtask

    // Drop valid, drain all results, then let the core settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CNT_W-1:0] count, input gtb_pkg::t_mode mode);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gtb_pkg::REG_NODE_COUNT;
        i_cfg_wdata <= CFG_W'(count);
        @(posedge i_clk);
        cfg_node_count = count;
        i_cfg_index <= gtb_pkg::REG_SEARCH_MODE;
        i_cfg_wdata <= CFG_W'(mode);
        @(posedge i_clk);
        cfg_mode = mode;
        i_cfg_we <= 1'b0;
        configs_written++;
    endtask

    function automatic logic [CNT_W-1:0] pick_node_count();
        case ($urandom_range(9))
            0: return '0;
            1: return CNT_W'(1);
            2: return CNT_W'(16);
            3: return '1;
            4: return CNT_W'($urandom_range(31, 17));
            default: return CNT_W'($urandom_range(16, 1));
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_row_bits();
        case ($urandom_range(3))
            0: return ROW_W'($urandom);
            1: return ROW_W'($urandom & $urandom);
            2: return ROW_W'($urandom & $urandom & $urandom);
            default: return ROW_W'((1 << $urandom_range(15)) | (1 << $urandom_range(15)));
        endcase
    endfunction

    // Write every row so no traversal ever reads an unwritten one.
    task automatic test_load_rows();
        logic [ROW_W-1:0] bits;
        for (int i = 0; i < ROW_W; i++) begin
            bits = ROW_W'((1 << ((i + 1) % ROW_W)) | (1 << ((i * 5 + 3) % ROW_W)) | (1 << i));
            if (i == 1) bits = '0;
            if (i == ROW_W - 1) bits = '1;
            send_request(gtb_pkg::OP_LOAD, NODE_W'(i), bits);
        end
    endtask

    task automatic test_reset_config_run();
        send_run();
    endtask

    task automatic test_search_modes();
        write_config(CNT_W'(16), gtb_pkg::MODE_DFS);
        send_run();
        write_config(CNT_W'(5), gtb_pkg::MODE_BFS);
        send_run();
        write_config(CNT_W'(9), gtb_pkg::MODE_DFS);
        send_run();
    endtask

    // Count one, zero and values beyond the row width.
    task automatic test_node_count_limits();
        write_config(CNT_W'(1), gtb_pkg::MODE_BFS);
        send_run();
        write_config(CNT_W'(1), gtb_pkg::MODE_DFS);
        send_run();
        write_config('0, gtb_pkg::MODE_BFS);
        send_run();
        write_config('1, gtb_pkg::MODE_DFS);
        send_run();
    endtask

    // Node 0 connected to every node including itself.
    task automatic test_full_row_self_loop();
        send_request(gtb_pkg::OP_LOAD, '0, '1);
        write_config(CNT_W'(16), gtb_pkg::MODE_BFS);
        send_run();
        write_config(CNT_W'(16), gtb_pkg::MODE_DFS);
        send_run();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        int chunk;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            write_config(pick_node_count(), gtb_pkg::t_mode'($urandom_range(1)));
            chunk = $urandom_range(14, 4);
            for (int k = 0; k < chunk && sent < n_items; k++) begin
                if ($urandom_range(99) < 62)
                    send_request(gtb_pkg::OP_LOAD, NODE_W'($urandom), pick_row_bits());
                else
                    send_run();
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            visits_checked++;
            if (expected_visits.size() == 0) begin
                report_mismatch("unexpected visited_node", int'(o_m_tdata[NODE_W-1:0]), -1);
            end else begin
                oldest_visit = expected_visits.pop_front();
                if (o_m_tdata[NODE_W-1:0] !== oldest_visit.node)
                    report_mismatch("visited_node", int'(o_m_tdata[NODE_W-1:0]),
                                    int'(oldest_visit.node));
                if (o_m_tlast !== oldest_visit.last)
                    report_mismatch("last", int'(o_m_tlast), int'(oldest_visit.last));
            end
        end
    end

    // End the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= gtb_pkg::OP_LOAD;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= gtb_pkg::REG_NODE_COUNT;
        i_cfg_wdata <= '0;
        loads_sent      = 0;
        runs_sent       = 0;
        configs_written = 0;
        send_idle_pct   = 26;
        recv_idle_pct   = 69;
        cfg_node_count  = gtb_pkg::NODE_COUNT_RST;
        cfg_mode        = gtb_pkg::MODE_BFS;
        foreach (adj_rows[i]) adj_rows[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_rows();
        test_reset_config_run();
        test_search_modes();
        test_node_count_limits();
        test_full_row_self_loop();
        test_random_phase(26, 69, 75);
        test_random_phase(69, 26, 75);
        test_random_phase(0, 0, 75);

        wait_idle();
        if (expected_visits.size() != 0)
            report_mismatch("results still pending", 0, expected_visits.size());
        $display("covered %0d row loads and %0d traversals over %0d register settings,",
                 loads_sent, runs_sent, configs_written);
        $display("checked %0d visited nodes, %0d mismatches", visits_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
